// ===== hdl/bpgs_pkg.sv =====
// ----------------------------------------------------------------------------
// bpgs_pkg: shared types, constants and profile tables
// Widths, register codes, the queue word layout and the two fixed
// voltage-to-percent profiles used by the gauge smoother.
// ----------------------------------------------------------------------------
package bpgs_pkg;

   // field widths
   localparam int MV_WIDTH    = 16;
   localparam int PCT_WIDTH   = 7;
   localparam int ALPHA_WIDTH = 16;
   localparam int WARM_WIDTH  = 4;

   // interpolation datapath: segment span fits 12 bits, quotient fits 7 bits
   localparam int DIV_WIDTH   = 12;
   localparam int PROD_WIDTH  = DIV_WIDTH + PCT_WIDTH;
   localparam int QUO_WIDTH   = 7;
   localparam int STEP_WIDTH  = $clog2(QUO_WIDTH);

   // exponential average datapath
   localparam int EMA_WIDTH   = ALPHA_WIDTH + PCT_WIDTH;
   localparam int SUM_WIDTH   = EMA_WIDTH + 1;

   // profile table
   localparam int FIXED_POINTS = 12;
   localparam int IDX_WIDTH    = 4;

   // queue between front and back
   localparam int QUEUE_DEPTH  = 2;

   // constants
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_MAX    = 16'hFFFF;
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET  = ALPHA_WIDTH'(65535 / (5 + 1));
   localparam logic [WARM_WIDTH-1:0]  WARMUP_RESET = 4'd5;
   localparam logic [SUM_WIDTH-1:0]   EMA_ROUND    = SUM_WIDTH'(32768);
   localparam logic [PCT_WIDTH-1:0]   LOW_END      = 7'd5;
   localparam logic [PCT_WIDTH-1:0]   HIGH_END     = 7'd95;
   localparam logic [PCT_WIDTH-1:0]   PCT_FULL     = 7'd100;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_EMA_ALPHA = 1'b0,
      CSR_WARMUP    = 1'b1
   } csr_index_type;

   // configuration values seen by the back end
   typedef struct packed {
      logic [ALPHA_WIDTH-1:0] alpha;
      logic [WARM_WIDTH-1:0]  warmup;
   } cfg_type;

   // one classified reading: raw = base_pct - product / divisor
   typedef struct packed {
      logic [PCT_WIDTH-1:0]  base_pct;
      logic [PROD_WIDTH-1:0] product;
      logic [DIV_WIDTH-1:0]  divisor;
      logic                  charging;
   } qentry_type;

   // profile voltage at an index, zero past the fixed points
   function automatic logic [MV_WIDTH-1:0] prof_mv(input logic chg,
                                                  input logic [IDX_WIDTH-1:0] idx);
      logic [MV_WIDTH-1:0] mv;
      mv = '0;
      if (chg) begin
         case (idx)
            4'd0:    mv = 16'd4200;
            4'd1:    mv = 16'd4195;
            4'd2:    mv = 16'd4159;
            4'd3:    mv = 16'd4100;
            4'd4:    mv = 16'd4032;
            4'd5:    mv = 16'd3986;
            4'd6:    mv = 16'd3909;
            4'd7:    mv = 16'd3905;
            4'd8:    mv = 16'd3809;
            4'd9:    mv = 16'd3795;
            4'd10:   mv = 16'd3750;
            default: mv = 16'd0;
         endcase
      end else begin
         case (idx)
            4'd0:    mv = 16'd4140;
            4'd1:    mv = 16'd4135;
            4'd2:    mv = 16'd4091;
            4'd3:    mv = 16'd4020;
            4'd4:    mv = 16'd3938;
            4'd5:    mv = 16'd3884;
            4'd6:    mv = 16'd3791;
            4'd7:    mv = 16'd3785;
            4'd8:    mv = 16'd3671;
            4'd9:    mv = 16'd3655;
            4'd10:   mv = 16'd3600;
            default: mv = 16'd0;
         endcase
      end
      return mv;
   endfunction

   // profile percent at an index, zero past the fixed points
   function automatic logic [PCT_WIDTH-1:0] prof_pct(input logic chg,
                                                    input logic [IDX_WIDTH-1:0] idx);
      logic [PCT_WIDTH-1:0] pct;
      pct = '0;
      case (idx)
         4'd0:    pct = 7'd100;
         4'd1:    pct = 7'd99;
         4'd2:    pct = 7'd91;
         4'd3:    pct = 7'd78;
         4'd4:    pct = 7'd63;
         4'd5:    pct = 7'd53;
         4'd6:    pct = 7'd36;
         4'd7:    pct = 7'd35;
         4'd8:    pct = 7'd14;
         4'd9:    pct = 7'd11;
         4'd10:   pct = 7'd1;
         default: pct = 7'd0;
      endcase
      // both profiles share the same percent column
      if (chg) begin
         pct = pct;
      end
      return pct;
   endfunction

endpackage

// ===== hdl/bpgs_front.sv =====
// ----------------------------------------------------------------------------
// bpgs_front: reading classifier
// Accepts a reading, finds its profile segment or clamp, and forms the
// interpolation product and divisor for the queue.
// ----------------------------------------------------------------------------
module bpgs_front
   import bpgs_pkg::*;
#(
   parameter int PROFILE_POINTS = 16
) (
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MV_WIDTH-1:0] req_voltage_mv,
   input  logic                req_charging,
   input  logic                q_full,
   output logic                q_push,
   output qentry_type          q_entry
);

   // last profile entry that can hold a nonzero point
   localparam int LAST = ((PROFILE_POINTS < FIXED_POINTS) ?
                          PROFILE_POINTS : FIXED_POINTS) - 1;
   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(LAST);
   localparam logic [IDX_WIDTH-1:0] TOP_IDX  = '0;

   logic [IDX_WIDTH-1:0] sel;
   logic [MV_WIDTH-1:0]  top_mv;
   logic [MV_WIDTH-1:0]  bot_mv;
   logic [MV_WIDTH-1:0]  a_mv;
   logic [MV_WIDTH-1:0]  b_mv;
   logic [PCT_WIDTH-1:0] a_pct;
   logic [PCT_WIDTH-1:0] b_pct;
   logic [DIV_WIDTH-1:0] span_mv;
   logic [DIV_WIDTH-1:0] drop_mv;
   logic [PCT_WIDTH-1:0] span_pct;

   // stall only while the queue has no room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // pick the first segment that brackets the voltage
   always_comb begin
      sel = '0;
      for (int i = LAST - 1; i >= 0; i--) begin
         if (req_voltage_mv <= prof_mv(req_charging, IDX_WIDTH'(i)) &&
             req_voltage_mv >  prof_mv(req_charging, IDX_WIDTH'(i + 1))) begin
            sel = IDX_WIDTH'(i);
         end
      end
   end

   assign top_mv   = prof_mv(req_charging, TOP_IDX);
   assign bot_mv   = prof_mv(req_charging, LAST_IDX);
   assign a_mv     = prof_mv(req_charging, sel);
   assign b_mv     = prof_mv(req_charging, sel + 4'd1);
   assign a_pct    = prof_pct(req_charging, sel);
   assign b_pct    = prof_pct(req_charging, sel + 4'd1);
   assign span_mv  = DIV_WIDTH'(a_mv - b_mv);
   assign drop_mv  = DIV_WIDTH'(a_mv - req_voltage_mv);
   assign span_pct = a_pct - b_pct;

   // clamp at the ends, otherwise hand on the interpolation terms
   always_comb begin
      q_entry.charging = req_charging;
      priority if (req_voltage_mv >= top_mv) begin
         q_entry.base_pct = prof_pct(req_charging, TOP_IDX);
         q_entry.product  = '0;
         q_entry.divisor  = DIV_WIDTH'(1);
      end else if (req_voltage_mv <= bot_mv) begin
         q_entry.base_pct = prof_pct(req_charging, LAST_IDX);
         q_entry.product  = '0;
         q_entry.divisor  = DIV_WIDTH'(1);
      end else begin
         q_entry.base_pct = a_pct;
         q_entry.product  = PROD_WIDTH'(drop_mv) * PROD_WIDTH'(span_pct);
         q_entry.divisor  = span_mv;
      end
   end

endmodule

// ===== hdl/bpgs_queue.sv =====
// ----------------------------------------------------------------------------
// bpgs_queue: short word queue
// Holds classified readings between the front and the back end.
// ----------------------------------------------------------------------------
module bpgs_queue
   import bpgs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_entry,
   output logic       full,
   output logic       not_empty,
   input  logic       pop,
   output qentry_type pop_entry
);

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(QUEUE_DEPTH);

   qentry_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/bpgs_back.sv =====
// ----------------------------------------------------------------------------
// bpgs_back: interpolation divider and smoothing filter
// Finishes the raw percentage with a serial divider, applies the charge
// direction rule, warmup loading and the exponential average.
// ----------------------------------------------------------------------------
module bpgs_back
   import bpgs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 q_valid,
   input  qentry_type           q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PCT_WIDTH-1:0] rsp_percent
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_ADJ,
      ST_UPD
   } state_type;

   localparam logic [STEP_WIDTH-1:0] STEP_FIRST = STEP_WIDTH'(QUO_WIDTH - 1);

   state_type             state_ff;
   logic [PROD_WIDTH-1:0] rem_ff;
   logic [DIV_WIDTH-1:0]  div_ff;
   logic [QUO_WIDTH-1:0]  quo_ff;
   logic [STEP_WIDTH-1:0] step_ff;
   logic [PCT_WIDTH-1:0]  base_ff;
   logic                  chg_ff;
   logic [PCT_WIDTH-1:0]  raw_ff;
   logic                  end_zone_ff;
   logic [PCT_WIDTH-1:0]  nudge_ff;
   logic [EMA_WIDTH-1:0]  new_term_ff;
   logic [EMA_WIDTH-1:0]  old_term_ff;
   logic [PCT_WIDTH-1:0]  avg_ff;
   logic                  warmed_ff;
   logic [WARM_WIDTH-1:0] warm_cnt_ff;
   logic                  rsp_valid_ff;
   logic [PCT_WIDTH-1:0]  rsp_percent_ff;

   logic [PROD_WIDTH-1:0] div_shift;
   logic                  div_fits;
   logic [PCT_WIDTH-1:0]  raw_interp;
   logic [PCT_WIDTH-1:0]  raw_dir;
   logic [SUM_WIDTH-1:0]  ema_sum;
   logic [PCT_WIDTH-1:0]  ema_pct;
   logic [PCT_WIDTH-1:0]  avg_next;
   logic [WARM_WIDTH-1:0] warm_cnt_next;
   logic                  out_free;
   logic                  rsp_load;

   assign q_pop       = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_percent = rsp_percent_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_load    = (state_ff == ST_UPD) && out_free;

   // one restoring quotient bit per cycle
   assign div_shift = PROD_WIDTH'(div_ff) << step_ff;
   assign div_fits  = (rem_ff >= div_shift);

   // raw percentage, then hold it against the charge direction
   assign raw_interp = base_ff - quo_ff;
   always_comb begin
      raw_dir = raw_interp;
      if (avg_ff != '0) begin
         if (chg_ff && raw_interp < avg_ff) begin
            raw_dir = avg_ff;
         end else if (!chg_ff && raw_interp > avg_ff) begin
            raw_dir = avg_ff;
         end
      end
   end

   // round the weighted sum back to a percentage
   assign ema_sum = SUM_WIDTH'(new_term_ff) + SUM_WIDTH'(old_term_ff) + EMA_ROUND;
   assign ema_pct = ema_sum[ALPHA_WIDTH +: PCT_WIDTH];

   assign warm_cnt_next = warm_cnt_ff + 1'b1;

   always_comb begin
      priority if (!warmed_ff) begin
         avg_next = raw_ff;
      end else if (end_zone_ff) begin
         avg_next = nudge_ff;
      end else begin
         avg_next = ema_pct;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_ff       <= '0;
         warmed_ff    <= 1'b0;
         warm_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new result word, or drop the current one once it is taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  rem_ff   <= q_entry.product;
                  div_ff   <= q_entry.divisor;
                  base_ff  <= q_entry.base_pct;
                  chg_ff   <= q_entry.charging;
                  quo_ff   <= '0;
                  step_ff  <= STEP_FIRST;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_fits) begin
                  rem_ff <= rem_ff - div_shift;
               end
               quo_ff  <= {quo_ff[QUO_WIDTH-2:0], div_fits};
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  state_ff <= ST_ADJ;
               end
            end
            ST_ADJ: begin
               raw_ff      <= raw_dir;
               end_zone_ff <= (!chg_ff && avg_ff <= LOW_END) ||
                              (chg_ff && avg_ff >= HIGH_END);
               if (chg_ff) begin
                  nudge_ff <= (raw_dir > avg_ff) ? avg_ff + 1'b1 : avg_ff;
               end else begin
                  nudge_ff <= (raw_dir < avg_ff) ? avg_ff - 1'b1 : avg_ff;
               end
               new_term_ff <= EMA_WIDTH'(cfg.alpha) * EMA_WIDTH'(raw_dir);
               old_term_ff <= EMA_WIDTH'(ALPHA_MAX - cfg.alpha) * EMA_WIDTH'(avg_ff);
               state_ff    <= ST_UPD;
            end
            ST_UPD: begin
               // wait for the output register to free up
               if (out_free) begin
                  avg_ff         <= avg_next;
                  rsp_percent_ff <= avg_next;
                  if (!warmed_ff) begin
                     warm_cnt_ff <= warm_cnt_next;
                     warmed_ff   <= (warm_cnt_next >= cfg.warmup);
                  end
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

endmodule

// ===== hdl/battery_percent_gauge_smoother.sv =====
// Battery gauge smoother: each voltage reading (mV plus charging flag) yields
// one charge percentage, 0 to 100. A reading is taken whenever the two-word
// queue behind the classifier has room, so short bursts are absorbed without
// stalling. The back end handles one reading at a time, in order: it takes
// the word from the queue, runs the serial divider that forms the
// interpolation quotient one bit per cycle, applies the direction rule and
// forms the average products, then updates the average and loads the output
// register once that register is free. It takes the next word from the queue
// only after that update. Configuration writes are always taken.
// ----------------------------------------------------------------------------
// battery_percent_gauge_smoother: top level
// Classifier front end, word queue and smoothing back end, plus the
// configuration registers for the filter weight and warmup length.
// ----------------------------------------------------------------------------
module battery_percent_gauge_smoother
   import bpgs_pkg::*;
#(
   parameter int PROFILE_POINTS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MV_WIDTH-1:0]        req_voltage_mv,
   input  logic                       req_charging,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [PCT_WIDTH-1:0]       rsp_percent,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ALPHA_WIDTH-1:0]     csr_data
);

   logic [ALPHA_WIDTH-1:0] alpha_ff;
   logic [WARM_WIDTH-1:0]  warmup_ff;
   cfg_type                cfg;
   logic                   q_push;
   logic                   q_full;
   logic                   q_valid;
   logic                   q_pop;
   qentry_type             q_in_entry;
   qentry_type             q_out_entry;

   // configuration registers take every write
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_RESET;
         warmup_ff <= WARMUP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_EMA_ALPHA: alpha_ff  <= csr_data;
            CSR_WARMUP:    warmup_ff <= csr_data[WARM_WIDTH-1:0];
         endcase
      end
   end

   assign cfg.alpha  = alpha_ff;
   assign cfg.warmup = warmup_ff;

   bpgs_front #(
      .PROFILE_POINTS (PROFILE_POINTS)
   ) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_voltage_mv (req_voltage_mv),
      .req_charging   (req_charging),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (q_in_entry)
   );

   bpgs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .full       (q_full),
      .not_empty  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_out_entry)
   );

   bpgs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_valid     (q_valid),
      .q_entry     (q_out_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_percent (rsp_percent)
   );

   // back end never takes a word from an empty queue
   a_pop_needs_word : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");

   // a result never leaves the percentage scale
   a_percent_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_percent <= PCT_FULL))
      else $error("result percentage above full scale");

   // the front never pushes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into a full queue");

endmodule

// ===== test/battery_percent_gauge_smoother_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for battery_percent_gauge_smoother
// Sends voltage readings through the valid/stall request channel in bursts
// and checks every percentage word against an in-bench gauge model. The model
// covers profile lookup, the direction rule, warmup, the exponential average
// and end-of-scale stepping. The filter registers are rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   import bpgs_pkg::*;

   localparam int PROFILE_POINTS = 16;
   localparam int DIRECTED_ROWS  = 22;
   localparam int PHASES         = 8;
   localparam int PHASE_READINGS = 118;
   localparam int NO_WANT        = -1;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_REPORTS    = 10;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HALF,
      STALL_HEAVY
   } stall_mode_type;

   typedef struct {
      logic [MV_WIDTH-1:0] mv;
      logic                chg;
      int                  want;
   } reading_row_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [MV_WIDTH-1:0]    req_voltage_mv = '0;
   logic                   req_charging   = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [PCT_WIDTH-1:0]   rsp_percent;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index      = CSR_EMA_ALPHA;
   logic [ALPHA_WIDTH-1:0] csr_data       = '0;

   // gauge model state and its copy of the registers
   logic [ALPHA_WIDTH-1:0] gauge_alpha     = ALPHA_RESET;
   logic [WARM_WIDTH-1:0]  gauge_warmup    = WARMUP_RESET;
   logic [PCT_WIDTH-1:0]   gauge_avg       = '0;
   logic                   gauge_filtering = 1'b0;
   logic [WARM_WIDTH-1:0]  gauge_count     = '0;

   logic [PCT_WIDTH-1:0]   expected_pct [$];
   logic [PCT_WIDTH-1:0]   want_pct;
   reading_row_type        directed_rows [DIRECTED_ROWS];
   int                     mismatches = 0;
   int                     cycles     = 0;
   int                     burst_left = 0;
   stall_mode_type         stall_mode = STALL_NONE;
   int                     stall_left = 0;

   battery_percent_gauge_smoother #(
      .PROFILE_POINTS(PROFILE_POINTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_voltage_mv (req_voltage_mv),
      .req_charging   (req_charging),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_percent    (rsp_percent),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // profile point at an index: both profiles share the percent column
   function automatic void profile_point(input logic chg, input int idx,
                                         output int mv, output int pct);
      int dis_mv;
      int chg_mv;
      dis_mv = 0;
      chg_mv = 0;
      pct    = 0;
      case (idx)
         0:  begin dis_mv = 4140; chg_mv = 4200; pct = 100; end
         1:  begin dis_mv = 4135; chg_mv = 4195; pct = 99;  end
         2:  begin dis_mv = 4091; chg_mv = 4159; pct = 91;  end
         3:  begin dis_mv = 4020; chg_mv = 4100; pct = 78;  end
         4:  begin dis_mv = 3938; chg_mv = 4032; pct = 63;  end
         5:  begin dis_mv = 3884; chg_mv = 3986; pct = 53;  end
         6:  begin dis_mv = 3791; chg_mv = 3909; pct = 36;  end
         7:  begin dis_mv = 3785; chg_mv = 3905; pct = 35;  end
         8:  begin dis_mv = 3671; chg_mv = 3809; pct = 14;  end
         9:  begin dis_mv = 3655; chg_mv = 3795; pct = 11;  end
         10: begin dis_mv = 3600; chg_mv = 3750; pct = 1;   end
         default: pct = 0;
      endcase
      mv = chg ? chg_mv : dis_mv;
   endfunction

   // raw percent: clamp to the profile ends, else interpolate the segment
   function automatic int profile_percent(input int mv, input logic chg);
      int top_mv, top_pct, bot_mv, bot_pct;
      int a_mv, a_pct, b_mv, b_pct;
      profile_point(chg, 0, top_mv, top_pct);
      profile_point(chg, PROFILE_POINTS - 1, bot_mv, bot_pct);
      if (mv >= top_mv) return top_pct;
      if (mv <= bot_mv) return bot_pct;
      for (int i = 0; i + 1 < PROFILE_POINTS; i++) begin
         profile_point(chg, i, a_mv, a_pct);
         profile_point(chg, i + 1, b_mv, b_pct);
         if (mv <= a_mv && mv > b_mv)
            return (a_pct - ((a_mv - mv) * (a_pct - b_pct)) / (a_mv - b_mv)) & 'h7f;
      end
      return 0;
   endfunction

   // advance the gauge model by one reading and return its percentage
   function automatic logic [PCT_WIDTH-1:0] predict_percent(input logic [MV_WIDTH-1:0] mv,
                                                            input logic chg);
      int     raw;
      int     cur;
      longint acc;
      raw = profile_percent(int'(mv), chg);
      cur = int'(gauge_avg);
      // hold the raw value against the charge direction once an average exists
      if (cur != 0) begin
         if (chg && raw < cur) raw = cur;
         else if (!chg && raw > cur) raw = cur;
      end
      if (!gauge_filtering) begin
         gauge_avg   = raw[PCT_WIDTH-1:0];
         gauge_count = gauge_count + 1'b1;
         if (gauge_count >= gauge_warmup) gauge_filtering = 1'b1;
         return raw[PCT_WIDTH-1:0];
      end
      if ((!chg && cur <= int'(LOW_END)) || (chg && cur >= int'(HIGH_END))) begin
         // step by one toward raw near the ends of the scale
         if (chg && raw > cur) cur = cur + 1;
         else if (!chg && raw < cur) cur = cur - 1;
      end else begin
         acc = longint'(gauge_alpha) * raw
             + longint'(65535 - int'(gauge_alpha)) * cur + 32768;
         cur = int'(acc >>> 16);
      end
      gauge_avg = cur[PCT_WIDTH-1:0];
      return gauge_avg;
   endfunction

   // drive one reading word, hold it until taken, then continue the burst or pause
   task automatic send_reading(input logic [MV_WIDTH-1:0] mv, input logic chg,
                               input int want);
      logic [PCT_WIDTH-1:0] pct;
      int                   gap;
      req_valid      <= 1'b1;
      req_voltage_mv <= mv;
      req_charging   <= chg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pct = predict_percent(mv, chg);
      expected_pct.push_back(want == NO_WANT ? pct : PCT_WIDTH'(want));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
         gap = $urandom_range(1, 24);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // write both filter registers back to back, junk in the unused warmup bits
   task automatic load_settings(input logic [ALPHA_WIDTH-1:0] alpha,
                                input logic [WARM_WIDTH-1:0] warm);
      logic [ALPHA_WIDTH-1:0] warm_word;
      warm_word = (ALPHA_WIDTH'($urandom) & 16'hFFF0) | ALPHA_WIDTH'(warm);
      csr_valid <= 1'b1;
      csr_index <= CSR_EMA_ALPHA;
      csr_data  <= alpha;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      gauge_alpha = alpha;
      csr_index <= CSR_WARMUP;
      csr_data  <= warm_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      gauge_warmup = warm_word[WARM_WIDTH-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid and wait until every expected word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_pct.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random readings: mostly directional sweeps, some noise and table points
   task automatic run_phase(input int count);
      int   sent, len, cur, step, pmv, ppct, lo, hi;
      logic chg;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
               chg = 1'($urandom);
               lo  = chg ? 3700 : 3550;
               hi  = chg ? 4260 : 4200;
               cur = $urandom_range(lo, hi);
               len = $urandom_range(4, 30);
               for (int k = 0; k < len && sent < count; k++) begin
                  step = $urandom_range(0, 20);
                  // mostly follow the charge direction, now and then move against it
                  if ($urandom_range(0, 7) == 0) step = -step;
                  cur = chg ? cur + step : cur - step;
                  if (cur < 0) cur = 0;
                  if (cur > 65535) cur = 65535;
                  send_reading(cur[MV_WIDTH-1:0], chg, NO_WANT);
                  sent++;
               end
            end
            7, 8: begin
               send_reading(MV_WIDTH'($urandom), 1'($urandom), NO_WANT);
               sent++;
            end
            default: begin
               chg = 1'($urandom);
               profile_point(chg, $urandom_range(0, 11), pmv, ppct);
               pmv = pmv + int'($urandom_range(0, 2)) - 1;
               if (pmv < 0) pmv = 0;
               send_reading(pmv[MV_WIDTH-1:0], chg, NO_WANT);
               sent++;
            end
         endcase
      end
   endtask

   // result side stalls in modes of random length
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(5, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
         STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
         default:     rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // compare each percentage word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pct.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected percent word: actual %0d", rsp_percent);
         end else begin
            want_pct = expected_pct.pop_front();
            if (rsp_percent !== want_pct) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("percent mismatch: expected %0d, actual %0d",
                           want_pct, rsp_percent);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("battery_percent_gauge_smoother regression: fail");
         $finish;
      end
   end

   initial begin
      // ends of the scale, zero voltage, direction clamp and warmup at reset settings
      directed_rows = '{
         '{16'd65535, 1'b0, 100},
         '{16'd0,     1'b0, 0},
         '{16'd4200,  1'b1, 100},
         '{16'd3750,  1'b1, 100},
         '{16'd4140,  1'b0, 100},
         '{16'd3900,  1'b0, NO_WANT},
         '{16'd4141,  1'b0, NO_WANT},
         '{16'd4139,  1'b0, NO_WANT},
         '{16'd3601,  1'b0, NO_WANT},
         '{16'd1,     1'b0, NO_WANT},
         '{16'd3600,  1'b0, NO_WANT},
         '{16'd0,     1'b0, NO_WANT},
         '{16'd3785,  1'b0, NO_WANT},
         '{16'd3749,  1'b1, NO_WANT},
         '{16'd3751,  1'b1, NO_WANT},
         '{16'd3909,  1'b1, NO_WANT},
         '{16'd4199,  1'b1, NO_WANT},
         '{16'd4201,  1'b1, NO_WANT},
         '{16'd65535, 1'b1, NO_WANT},
         '{16'd32768, 1'b0, NO_WANT},
         '{16'd21845, 1'b1, NO_WANT},
         '{16'd43690, 1'b0, NO_WANT}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_reading(directed_rows[r].mv, directed_rows[r].chg, directed_rows[r].want);
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       load_settings(16'd0, 4'd0);
            1:       load_settings(ALPHA_MAX, 4'd15);
            2:       load_settings(16'd1, 4'd1);
            3:       load_settings(16'd65534, 4'd14);
            default: load_settings(ALPHA_WIDTH'($urandom_range(0, 65535)),
                                   WARM_WIDTH'($urandom_range(0, 15)));
         endcase
         run_phase(PHASE_READINGS);
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_pct.size() == 0) begin
         $display("battery_percent_gauge_smoother regression: pass");
      end else begin
         $display("battery_percent_gauge_smoother regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/bpgs_pkg.sv
hdl/bpgs_front.sv
hdl/bpgs_queue.sv
hdl/bpgs_back.sv
hdl/battery_percent_gauge_smoother.sv
test/battery_percent_gauge_smoother_tb.sv
